// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle where ante holds.
`define PGE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that expr holds in every cycle.
`define PGE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

`endif

// ===== rtl/pge_pkg.sv =====
// ----------------------------------------------------------------------------
// pge_pkg
// Shared widths, codes and types of the pairwise gravity engine.
// ----------------------------------------------------------------------------
package pge_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_DIM      = 8;
    localparam int VERTEX_W     = 10;
    localparam int DIM_IDX_W    = 3;
    localparam int ADDR_W       = VERTEX_W + DIM_IDX_W;
    localparam int STORE_DEPTH  = MAX_VERTICES * MAX_DIM;
    localparam int COORD_W      = 32;
    localparam int COUNT_W      = 11;
    localparam int DIMREG_W     = 4;
    localparam int STR_W        = 48;
    localparam int RES_W        = 64;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 68;
    localparam int SQ_SHIFT     = 32;
    localparam int ROOT_W       = (SQ_W + SQ_SHIFT) / 2;
    localparam int MUL_A_W      = SQ_W;
    localparam int MUL_B_W      = ROOT_W;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W      = STR_W + DIFF_W + 40;
    localparam int DIV_D_W      = MUL_P_W;
    localparam int STEP_W       = 4;
    localparam int STEP_RECIP   = 1311;
    localparam int STEP_SHIFT   = 17;
    localparam int IN_DATA_W    = 56;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_POTENTIAL = 2'd1;
    localparam logic [1:0] OP_ACCEL     = 2'd2;

    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_DIMENSION    = 2'd1;
    localparam logic [1:0] REG_STRENGTH     = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/pge_ram.sv =====
// ----------------------------------------------------------------------------
// pge_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pge_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/pge_mul.sv =====
// ----------------------------------------------------------------------------
// pge_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pge_mul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [pge_pkg::MUL_A_W-1:0] a,
    input  logic [pge_pkg::MUL_B_W-1:0] b,
    output pge_pkg::unit_stat_t       stat,
    output logic [pge_pkg::MUL_P_W-1:0] p
);
    import pge_pkg::*;

    logic               run_reg;
    logic               done_reg;
    logic [MUL_P_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg   <= MUL_P_W'(a);
                b_reg   <= b;
                p_reg   <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                // stop as soon as no multiplier bits remain
                if (b_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    if (b_reg[0]) begin
                        p_reg <= p_reg + a_reg;
                    end
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                end
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign p         = p_reg;
endmodule

// ===== rtl/pge_div.sv =====
// ----------------------------------------------------------------------------
// pge_div
// Restoring divider, one quotient bit per cycle, with an overflow flag.
// ----------------------------------------------------------------------------
module pge_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pge_pkg::DIV_N_W-1:0] num,
    input  logic [pge_pkg::DIV_D_W-1:0] den,
    output pge_pkg::unit_stat_t         stat,
    output logic [pge_pkg::RES_W-1:0]   quo,
    output logic                        ovf
);
    import pge_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               run_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_N_W-1:0] num_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [RES_W-1:0]   q_reg;
    logic               ovf_reg;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   rem_diff;
    logic               ge;

    assign rem_sh   = {rem_reg, num_reg[DIV_N_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                q_reg   <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= CNT_W'(DIV_N_W);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                num_reg <= num_reg << 1;
                rem_reg <= ge ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
                // remember any quotient bit that leaves the low word
                ovf_reg <= ovf_reg | q_reg[RES_W-1];
                q_reg   <= {q_reg[RES_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign quo       = q_reg;
    assign ovf       = ovf_reg | q_reg[RES_W-1];
endmodule

// ===== rtl/pge_sqrt.sv =====
// ----------------------------------------------------------------------------
// pge_sqrt
// Digit-by-digit integer square root of x * 2^32, one root bit per cycle.
// ----------------------------------------------------------------------------
module pge_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pge_pkg::SQ_W-1:0]   x,
    output pge_pkg::unit_stat_t        stat,
    output logic [pge_pkg::ROOT_W-1:0] root
);
    import pge_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_diff;
    logic              ge;

    assign rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rem_diff = rem_sh - trial;
    assign ge       = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= {x, SQ_SHIFT'(0)};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W);
                run_reg  <= 1'b1;
            end else if (run_reg) begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;
endmodule

// ===== rtl/pairwise_gravity_engine.sv =====
// ----------------------------------------------------------------------------
// pairwise_gravity_engine
// Fixed-point n-body potential and acceleration engine over a position table.
// ----------------------------------------------------------------------------
// Coordinate writes leave the block ready again at once. A potential query
// divides strength by the root of the summed squared differences; for an
// acceleration query each sampled vertex (every step-th, step n/100 but at
// least one) adds a multiply and a divide per differing axis, and each axis
// is then scaled by the step. The time is set by the shared bit-serial units:
// the multiplier retires one bit, the square root and the divider one result
// bit per cycle, and the position RAM gives one coordinate per cycle. The
// position table is not cleared after reset; an input is taken only while no
// query is in progress, and may be taken while the last result of the
// previous query still waits on the output.
`include "assert_macros.svh"

module pairwise_gravity_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [pge_pkg::STR_W-1:0]     cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // vertex_a[9:0], vertex_b[19:10], coord_index[22:20], coord_value[54:23]
    input  logic [pge_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                    s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_value[63:0]
    output logic [pge_pkg::RES_W-1:0]     m_axis_tdata,
    // result_component[2:0]
    output logic [pge_pkg::DIM_IDX_W-1:0] m_axis_tuser,
    output logic                          m_axis_tlast
);
    import pge_pkg::*;

    localparam logic [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_NEXT_V, S_SD_RDA, S_SD_RDB, S_SD_DIFF, S_SD_MUL, S_SQ_WAIT,
        S_POT_DIV, S_DEN_MUL, S_TERM_CHK, S_TERM_MUL, S_TERM_DIV,
        S_SCALE_GO, S_SCALE_MUL, S_EMIT
    } state_t;

    function automatic logic [RES_W-1:0] sat_mag(input logic neg,
                                                 input logic [RES_W-1:0] mag,
                                                 input logic big);
        logic [RES_W-1:0] r;
        if (big || mag[RES_W-1]) begin
            r = neg ? SAT_MIN : SAT_MAX;
        end else begin
            r = neg ? (~mag + 1'b1) : mag;
        end
        return r;
    endfunction

    function automatic logic [RES_W-1:0] sat_add(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b);
        logic [RES_W-1:0] s;
        s = a + b;
        if (a[RES_W-1] == b[RES_W-1] && s[RES_W-1] != a[RES_W-1]) begin
            s = a[RES_W-1] ? SAT_MIN : SAT_MAX;
        end
        return s;
    endfunction

    state_t               state_reg;
    logic [COUNT_W-1:0]   vcount_reg;
    logic [DIMREG_W-1:0]  dim_reg;
    logic [STR_W-1:0]     strength_reg;

    logic                 mode_acc_reg;
    logic [DIM_IDX_W-1:0] dim_last_reg;
    logic [DIM_IDX_W-1:0] emit_last_reg;
    logic [DIM_IDX_W-1:0] idx_reg;
    logic [VERTEX_W-1:0]  va_reg;
    logic [VERTEX_W-1:0]  vb_reg;
    logic [COUNT_W-1:0]   n_reg;
    logic [COUNT_W-1:0]   j_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [COORD_W-1:0]   ca_reg;
    logic [SQ_W-1:0]      s_reg;
    logic [DIFF_W-1:0]    dring_reg [MAX_DIM];
    logic [RES_W-1:0]     acc_reg [MAX_DIM];

    logic                 mul_go_reg;
    logic [MUL_A_W-1:0]   mul_a_reg;
    logic [MUL_B_W-1:0]   mul_b_reg;
    logic                 div_go_reg;
    logic [DIV_N_W-1:0]   div_num_reg;
    logic [DIV_D_W-1:0]   div_den_reg;
    logic                 sq_go_reg;

    logic                 m_valid_reg;
    logic [RES_W-1:0]     m_data_reg;
    logic [DIM_IDX_W-1:0] m_comp_reg;
    logic                 m_last_reg;

    unit_stat_t           mul_stat;
    unit_stat_t           div_stat;
    unit_stat_t           sq_stat;
    logic [MUL_P_W-1:0]   mul_p;
    logic [RES_W-1:0]     div_q;
    logic                 div_ovf;
    logic [ROOT_W-1:0]    sq_root;
    logic [COORD_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic                 ram_we;
    logic [2:0]           unit_done_vec;

    // input fields
    logic [1:0]           in_op;
    logic [VERTEX_W-1:0]  in_va;
    logic [VERTEX_W-1:0]  in_vb;
    logic [DIM_IDX_W-1:0] in_ci;
    logic [COORD_W-1:0]   in_cv;

    logic [COUNT_W-1:0]   n_cur;
    logic [DIM_IDX_W-1:0] dim_last_cur;
    logic [2*COUNT_W-1:0] step_prod;
    logic [STEP_W-1:0]    step_raw;
    logic [STEP_W-1:0]    step_cur;
    logic [VERTEX_W-1:0]  pot_a;
    logic [VERTEX_W-1:0]  pot_b;
    logic [COUNT_W-1:0]   n_less1;

    logic [DIFF_W-1:0]    diff;
    logic [DIFF_W-1:0]    m_diff;
    logic [DIFF_W-1:0]    d_cur;
    logic [DIFF_W-1:0]    m_term;
    logic [SQ_W-1:0]      s_next;
    logic [RES_W-1:0]     acc0;
    logic [RES_W-1:0]     acc_mag;
    logic [RES_W-1:0]     term_val;
    logic [RES_W-1:0]     acc_sum;
    logic [RES_W-1:0]     pot_val;
    logic [RES_W-1:0]     scale_val;
    logic                 idx_last;

    assign in_op = s_axis_tuser;
    assign in_va = s_axis_tdata[VERTEX_W-1:0];
    assign in_vb = s_axis_tdata[2*VERTEX_W-1:VERTEX_W];
    assign in_ci = s_axis_tdata[2*VERTEX_W +: DIM_IDX_W];
    assign in_cv = s_axis_tdata[2*VERTEX_W+DIM_IDX_W +: COORD_W];

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        n_cur = (vcount_reg > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                      : vcount_reg;
        if (dim_reg == '0) begin
            dim_last_cur = '0;
        end else if (dim_reg > DIMREG_W'(MAX_DIM)) begin
            dim_last_cur = DIM_IDX_W'(MAX_DIM - 1);
        end else begin
            dim_last_cur = DIM_IDX_W'(dim_reg - 1'b1);
        end
        // n / 100 by reciprocal multiply, exact for the count range
        step_prod = (2*COUNT_W)'(n_cur) * (2*COUNT_W)'(STEP_RECIP);
        step_raw  = step_prod[STEP_SHIFT +: STEP_W];
        step_cur  = (step_raw == '0) ? STEP_W'(1) : step_raw;
        n_less1   = n_cur - 1'b1;
        pot_a     = ({1'b0, in_va} < n_cur) ? in_va : '0;
        pot_b     = ({1'b0, in_vb} < n_cur) ? in_vb : n_less1[VERTEX_W-1:0];
    end

    always_comb begin
        diff      = {ram_rdata[COORD_W-1], ram_rdata} - {ca_reg[COORD_W-1], ca_reg};
        m_diff    = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        d_cur     = dring_reg[0];
        m_term    = d_cur[DIFF_W-1] ? (~d_cur + 1'b1) : d_cur;
        s_next    = s_reg + mul_p[SQ_W-1:0];
        acc0      = acc_reg[0];
        acc_mag   = acc0[RES_W-1] ? (~acc0 + 1'b1) : acc0;
        term_val  = sat_mag(d_cur[DIFF_W-1], div_q, div_ovf);
        acc_sum   = sat_add(acc0, term_val);
        pot_val   = sat_mag(1'b1, div_q, div_ovf);
        scale_val = sat_mag(acc0[RES_W-1], mul_p[RES_W-1:0], |mul_p[MUL_P_W-1:RES_W]);
        idx_last  = (idx_reg == dim_last_reg);
        ram_raddr = (state_reg == S_SD_RDA) ? {va_reg, idx_reg} : {vb_reg, idx_reg};
        ram_we    = s_axis_tvalid && s_axis_tready && (in_op == OP_WRITE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vcount_reg   <= '0;
            dim_reg      <= DIMREG_W'(3);
            strength_reg <= '0;
            mul_go_reg   <= 1'b0;
            div_go_reg   <= 1'b0;
            sq_go_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
        end else begin
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
            sq_go_reg  <= 1'b0;
            if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                priority if (cfg_index == REG_VERTEX_COUNT) begin
                    vcount_reg <= cfg_wdata[COUNT_W-1:0];
                end else if (cfg_index == REG_DIMENSION) begin
                    dim_reg <= cfg_wdata[DIMREG_W-1:0];
                end else if (cfg_index == REG_STRENGTH) begin
                    strength_reg <= cfg_wdata;
                end else begin
                    // unused index: drop the write
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (in_op == OP_POTENTIAL || in_op == OP_ACCEL) begin
                            for (int k = 0; k < MAX_DIM; k++) begin
                                acc_reg[k] <= '0;
                            end
                            dim_last_reg <= dim_last_cur;
                            idx_reg      <= '0;
                            s_reg        <= '0;
                        end
                        if (in_op == OP_POTENTIAL) begin
                            mode_acc_reg  <= 1'b0;
                            emit_last_reg <= '0;
                            va_reg        <= pot_a;
                            vb_reg        <= pot_b;
                            if (n_cur == '0 || pot_a == pot_b || strength_reg == '0) begin
                                state_reg <= S_EMIT;
                            end else begin
                                state_reg <= S_SD_RDA;
                            end
                        end else if (in_op == OP_ACCEL) begin
                            mode_acc_reg  <= 1'b1;
                            emit_last_reg <= dim_last_cur;
                            va_reg        <= in_va;
                            n_reg         <= n_cur;
                            step_reg      <= step_cur;
                            j_reg         <= '0;
                            if (n_cur == '0 || {1'b0, in_va} >= n_cur
                                    || strength_reg == '0) begin
                                state_reg <= S_EMIT;
                            end else begin
                                state_reg <= S_NEXT_V;
                            end
                        end
                    end
                end
                S_NEXT_V: begin
                    if (j_reg >= n_reg) begin
                        idx_reg   <= '0;
                        state_reg <= S_SCALE_GO;
                    end else begin
                        j_reg <= j_reg + COUNT_W'(step_reg);
                        // skip the target itself
                        if (j_reg[VERTEX_W-1:0] != va_reg) begin
                            vb_reg    <= j_reg[VERTEX_W-1:0];
                            s_reg     <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_SD_RDA;
                        end
                    end
                end
                S_SD_RDA: begin
                    state_reg <= S_SD_RDB;
                end
                S_SD_RDB: begin
                    ca_reg    <= ram_rdata;
                    state_reg <= S_SD_DIFF;
                end
                S_SD_DIFF: begin
                    for (int k = 0; k < MAX_DIM; k++) begin
                        if (DIM_IDX_W'(k) == dim_last_reg) begin
                            dring_reg[k] <= diff;
                        end else begin
                            dring_reg[k] <= dring_reg[DIM_IDX_W'(k + 1)];
                        end
                    end
                    mul_a_reg  <= MUL_A_W'(m_diff);
                    mul_b_reg  <= MUL_B_W'(m_diff);
                    mul_go_reg <= 1'b1;
                    state_reg  <= S_SD_MUL;
                end
                S_SD_MUL: begin
                    if (mul_stat.done) begin
                        s_reg <= s_next;
                        if (idx_last) begin
                            idx_reg <= '0;
                            if (s_next == '0) begin
                                if (mode_acc_reg) begin
                                    state_reg <= S_NEXT_V;
                                end else begin
                                    acc_reg[0] <= SAT_MIN;
                                    state_reg  <= S_EMIT;
                                end
                            end else begin
                                sq_go_reg <= 1'b1;
                                state_reg <= S_SQ_WAIT;
                            end
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SD_RDA;
                        end
                    end
                end
                S_SQ_WAIT: begin
                    if (sq_stat.done) begin
                        if (mode_acc_reg) begin
                            mul_a_reg  <= s_reg;
                            mul_b_reg  <= sq_root;
                            mul_go_reg <= 1'b1;
                            state_reg  <= S_DEN_MUL;
                        end else begin
                            div_num_reg <= DIV_N_W'({strength_reg, 24'd0});
                            div_den_reg <= DIV_D_W'(sq_root);
                            div_go_reg  <= 1'b1;
                            state_reg   <= S_POT_DIV;
                        end
                    end
                end
                S_POT_DIV: begin
                    if (div_stat.done) begin
                        acc_reg[0] <= pot_val;
                        state_reg  <= S_EMIT;
                    end
                end
                S_DEN_MUL: begin
                    if (mul_stat.done) begin
                        div_den_reg <= mul_p;
                        idx_reg     <= '0;
                        state_reg   <= S_TERM_CHK;
                    end
                end
                S_TERM_CHK: begin
                    if (m_term == '0) begin
                        // no pull along this axis: rotate both rings and move on
                        for (int k = 0; k < MAX_DIM; k++) begin
                            if (DIM_IDX_W'(k) == dim_last_reg) begin
                                dring_reg[k] <= d_cur;
                                acc_reg[k]   <= acc0;
                            end else begin
                                dring_reg[k] <= dring_reg[DIM_IDX_W'(k + 1)];
                                acc_reg[k]   <= acc_reg[DIM_IDX_W'(k + 1)];
                            end
                        end
                        if (idx_last) begin
                            idx_reg   <= '0;
                            state_reg <= S_NEXT_V;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else begin
                        mul_a_reg  <= MUL_A_W'(m_term);
                        mul_b_reg  <= MUL_B_W'(strength_reg);
                        mul_go_reg <= 1'b1;
                        state_reg  <= S_TERM_MUL;
                    end
                end
                S_TERM_MUL: begin
                    if (mul_stat.done) begin
                        div_num_reg <= {mul_p[DIV_N_W-41:0], 40'd0};
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_TERM_DIV;
                    end
                end
                S_TERM_DIV: begin
                    if (div_stat.done) begin
                        for (int k = 0; k < MAX_DIM; k++) begin
                            if (DIM_IDX_W'(k) == dim_last_reg) begin
                                dring_reg[k] <= d_cur;
                                acc_reg[k]   <= acc_sum;
                            end else begin
                                dring_reg[k] <= dring_reg[DIM_IDX_W'(k + 1)];
                                acc_reg[k]   <= acc_reg[DIM_IDX_W'(k + 1)];
                            end
                        end
                        if (idx_last) begin
                            idx_reg   <= '0;
                            state_reg <= S_NEXT_V;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_TERM_CHK;
                        end
                    end
                end
                S_SCALE_GO: begin
                    mul_a_reg  <= MUL_A_W'(acc_mag);
                    mul_b_reg  <= MUL_B_W'(step_reg);
                    mul_go_reg <= 1'b1;
                    state_reg  <= S_SCALE_MUL;
                end
                S_SCALE_MUL: begin
                    if (mul_stat.done) begin
                        for (int k = 0; k < MAX_DIM; k++) begin
                            if (DIM_IDX_W'(k) == dim_last_reg) begin
                                acc_reg[k] <= scale_val;
                            end else begin
                                acc_reg[k] <= acc_reg[DIM_IDX_W'(k + 1)];
                            end
                        end
                        if (idx_last) begin
                            idx_reg   <= '0;
                            state_reg <= S_EMIT;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SCALE_GO;
                        end
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= acc0;
                        m_comp_reg  <= idx_reg;
                        m_last_reg  <= (idx_reg == emit_last_reg);
                        for (int k = 0; k < MAX_DIM; k++) begin
                            if (DIM_IDX_W'(k) == dim_last_reg) begin
                                acc_reg[k] <= acc0;
                            end else begin
                                acc_reg[k] <= acc_reg[DIM_IDX_W'(k + 1)];
                            end
                        end
                        if (idx_reg == emit_last_reg) begin
                            idx_reg   <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_comp_reg;
    assign m_axis_tlast  = m_last_reg;

    pge_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (COORD_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr ({in_va, in_ci}),
        .wdata (in_cv),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pge_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .stat    (mul_stat),
        .p       (mul_p)
    );

    pge_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .stat    (div_stat),
        .quo     (div_q),
        .ovf     (div_ovf)
    );

    pge_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_go_reg),
        .x       (s_reg),
        .stat    (sq_stat),
        .root    (sq_root)
    );

    assign unit_done_vec = {mul_stat.done, div_stat.done, sq_stat.done};

    `PGE_ASSERT_IMPLY(a_mul_start_idle, mul_go_reg, !mul_stat.busy, "multiplier restarted while busy")
    `PGE_ASSERT_IMPLY(a_div_start_idle, div_go_reg, !div_stat.busy, "divider restarted while busy")
    `PGE_ASSERT_ALWAYS(a_single_done, $onehot0(unit_done_vec), "two serial units finished together")
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise gravity engine testbench
// Drives coordinate writes, potential and acceleration queries over several
// register settings, predicts every result in fixed point and compares each
// result transfer field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
import pge_pkg::*;

typedef struct {
    logic [63:0] value;
    logic [2:0]  comp;
    logic        last;
} grav_result_t;

class gravity_scoreboard;
    int          pos [MAX_VERTICES][MAX_DIM];
    bit          written [MAX_VERTICES][MAX_DIM];
    logic [10:0] count_reg = 0;
    logic [3:0]  dim_reg = 3;
    logic [47:0] strength = 0;
    grav_result_t expected_results [$];
    int          errors = 0;

    function int eff_n();
        return (count_reg < MAX_VERTICES) ? int'(count_reg) : MAX_VERTICES;
    endfunction

    function int eff_dim();
        if (dim_reg == 0) return 1;
        return (dim_reg > MAX_DIM) ? MAX_DIM : int'(dim_reg);
    endfunction

    function int accel_step();
        int s;
        s = eff_n() / 100;
        return (s == 0) ? 1 : s;
    endfunction

    // Vertices whose coordinates a query is going to read.
    function void vertices_read(logic [1:0] op, int va, int vb, ref int list [$]);
        int n, a, b;
        n = eff_n();
        list.delete();
        if (n == 0 || strength == 0) return;
        if (op == OP_POTENTIAL) begin
            a = (va < n) ? va : 0;
            b = (vb < n) ? vb : n - 1;
            if (a != b) begin
                list.push_back(a);
                list.push_back(b);
            end
        end else if (op == OP_ACCEL && va < n) begin
            list.push_back(va);
            for (int j = 0; j < n; j += accel_step())
                list.push_back(j);
        end
    endfunction

    function logic [127:0] isqrt(logic [127:0] x);
        logic [63:0]  r, c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (x >= {64'd0, c} * {64'd0, c}) r = c;
        end
        return {64'd0, r};
    endfunction

    function logic [127:0] sq_dist(int a, int b);
        logic [127:0] s;
        longint       d;
        logic [63:0]  m;
        s = 0;
        for (int i = 0; i < eff_dim(); i++) begin
            d = longint'(pos[b][i]) - longint'(pos[a][i]);
            m = (d < 0) ? -d : d;
            s = s + {64'd0, m} * {64'd0, m};
        end
        return s;
    endfunction

    function logic [63:0] saturate(bit neg, logic [127:0] q);
        if (q >= (128'd1 << 63)) return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -q[63:0] : q[63:0];
    endfunction

    function longint add_sat(longint a, longint b);
        logic signed [64:0] t;
        t = a;
        t = t + b;
        if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (t < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
        return t[63:0];
    endfunction

    function longint scale_sat(longint a, int k);
        logic signed [71:0] t;
        t = a;
        t = t * k;
        if (t > 72'sh00_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (t < -72'sh00_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
        return t[63:0];
    endfunction

    function void set_reg(logic [1:0] idx, logic [47:0] v);
        if (idx == REG_VERTEX_COUNT) count_reg = v[10:0];
        else if (idx == REG_DIMENSION) dim_reg = v[3:0];
        else if (idx == REG_STRENGTH) strength = v;
    endfunction

    function void note_input(logic [1:0] op, int va, int vb, int ci, int cv);
        grav_result_t r;
        logic [127:0] s, rt, q;
        longint       acc [MAX_DIM];
        longint       d;
        logic [63:0]  m;
        int           n, a, b, dim, step;
        n = eff_n();
        dim = eff_dim();
        if (op == OP_WRITE) begin
            pos[va][ci] = cv;
            written[va][ci] = 1;
        end else if (op == OP_POTENTIAL) begin
            r.value = 0;
            r.comp = 0;
            r.last = 1;
            if (n != 0) begin
                a = (va < n) ? va : 0;
                b = (vb < n) ? vb : n - 1;
                if (a != b && strength != 0) begin
                    s = sq_dist(a, b);
                    if (s == 0) begin
                        r.value = 64'h8000_0000_0000_0000;
                    end else begin
                        rt = isqrt(s << 32);
                        q = ({80'd0, strength} << 24) / rt;
                        r.value = saturate(1, q);
                    end
                end
            end
            expected_results.push_back(r);
        end else if (op == OP_ACCEL) begin
            step = accel_step();
            foreach (acc[i]) acc[i] = 0;
            if (n != 0 && va < n && strength != 0) begin
                for (int j = 0; j < n; j += step) begin
                    if (j == va) continue;
                    s = sq_dist(va, j);
                    if (s == 0) continue;
                    rt = s * isqrt(s << 32);
                    for (int i = 0; i < dim; i++) begin
                        d = longint'(pos[j][i]) - longint'(pos[va][i]);
                        m = (d < 0) ? -d : d;
                        if (m == 0) continue;
                        q = (({80'd0, strength} * {64'd0, m}) << 40) / rt;
                        acc[i] = add_sat(acc[i], saturate(d < 0, q));
                    end
                end
                for (int i = 0; i < dim; i++) acc[i] = scale_sat(acc[i], step);
            end
            for (int i = 0; i < dim; i++) begin
                r.value = acc[i];
                r.comp = i[2:0];
                r.last = (i + 1 == dim);
                expected_results.push_back(r);
            end
        end
    endfunction

    function void check_result(logic [63:0] value, logic [2:0] comp, logic last);
        grav_result_t e;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result value=%h comp=%0d last=%0d",
                     $time, value, comp, last);
            errors++;
            return;
        end
        e = expected_results.pop_front();
        if (value !== e.value) begin
            $display("%0t: value expected %h actual %h", $time, e.value, value);
            errors++;
        end
        if (comp !== e.comp) begin
            $display("%0t: component expected %0d actual %0d", $time, e.comp, comp);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: last expected %0d actual %0d", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int STALL_LIMIT = 300000;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_wr_en = 0;
    logic [1:0]           cfg_index = 0;
    logic [STR_W-1:0]     cfg_wdata = 0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = 0;
    logic [1:0]           s_axis_tuser = 0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [RES_W-1:0]     m_axis_tdata;
    logic [DIM_IDX_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    gravity_scoreboard sb = new();
    bit quiet = 0;          // no gaps or stalls while set
    bit long_hold_req = 0;
    int idle_cycles = 0;
    int accel_budget;

    pairwise_gravity_engine dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Result side: check each transfer, then pick tready for the next cycle.
    int hold = 0;
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (long_hold_req) begin
            long_hold_req <= 0;
            hold = 4000;
        end
        if (hold > 0) begin
            hold--;
            m_axis_tready <= 0;
        end else if (!quiet && $urandom_range(7) == 0) begin
            hold = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(19);
        if (r < 13) return 0;
        if (r < 19) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_raw(logic [1:0] op, int va, int vb, int ci, int cv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {1'b0, cv[31:0], ci[2:0], vb[9:0], va[9:0]};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(op, va, vb, ci, cv);
    endtask

    function int pick_coord(int v, int c);
        int r, o;
        r = $urandom_range(15);
        o = $urandom_range(7);
        if (r < 4 && sb.written[o][c]) return sb.pos[o][c];
        if (r == 4) return 32'h8000_0000;
        if (r == 5) return 32'h7FFF_FFFF;
        if (r < 12) return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        return $urandom();
    endfunction

    // Fill in any coordinate the query would read that was never written.
    task automatic send_query(logic [1:0] op, int va, int vb);
        int list [$];
        sb.vertices_read(op, va, vb, list);
        foreach (list[k])
            for (int c = 0; c < MAX_DIM; c++)
                if (!sb.written[list[k]][c])
                    send_raw(OP_WRITE, list[k], $urandom_range(1023), c, pick_coord(list[k], c));
        send_raw(op, va, vb, $urandom_range(7), $urandom());
    endtask

    task automatic drain();
        @(posedge aclk);
        s_axis_tvalid <= 0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] v);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic configure(int cnt, int dim, logic [47:0] s);
        drain();
        write_reg(REG_VERTEX_COUNT, cnt);
        write_reg(REG_DIMENSION, dim);
        write_reg(REG_STRENGTH, s);
        @(posedge aclk);
    endtask

    task automatic random_item();
        int r, n, va;
        n = sb.eff_n();
        r = $urandom_range(99);
        if (r < 30) begin
            va = (n > 0 && n < 16) ? $urandom_range(n + 1) : $urandom_range(1023);
            send_raw(OP_WRITE, va, $urandom_range(1023), $urandom_range(7),
                     pick_coord(va, 0));
        end else if (r < 65) begin
            if ($urandom_range(3) == 0)
                send_query(OP_POTENTIAL, $urandom_range(1023), $urandom_range(1023));
            else
                send_query(OP_POTENTIAL, $urandom_range(n + 1), $urandom_range(n + 1));
        end else if (r < 95 && accel_budget > 0) begin
            accel_budget--;
            va = ($urandom_range(5) == 0) ? $urandom_range(1023) : $urandom_range(n);
            send_query(OP_ACCEL, va, $urandom_range(1023));
        end else begin
            send_raw(2'd3, $urandom_range(1023), $urandom_range(1023), $urandom_range(7),
                     $urandom());
        end
    endtask

    function logic [47:0] pick_strength();
        case ($urandom_range(4))
            0: return 48'hFFFF_FFFF_FFFF;
            1: return 0;
            2: return {$urandom(), $urandom()};
            default: return $urandom_range(32'h00FF_FFFF) << $urandom_range(24);
        endcase
    endfunction

    initial begin
        int cnt, dim;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Empty table under reset settings, and the unused operation.
        send_query(OP_POTENTIAL, 3, 9);
        send_query(OP_ACCEL, 0, 0);
        send_raw(2'd3, 1023, 1023, 7, 32'hFFFF_FFFF);

        configure(4, 3, 48'hFFFF_FFFF_FFFF);
        for (int c = 0; c < MAX_DIM; c++) begin
            send_raw(OP_WRITE, 0, 0, c, 32'h0001_0000 * c);
            send_raw(OP_WRITE, 1, 0, c, 32'h0001_0000 * c);   // same point as vertex 0
        end
        send_raw(OP_WRITE, 2, 1023, 0, 32'h8000_0000);
        send_raw(OP_WRITE, 3, 1023, 0, 32'h7FFF_FFFF);
        send_query(OP_POTENTIAL, 0, 0);        // same vertex
        send_query(OP_POTENTIAL, 0, 1);        // zero distance
        send_query(OP_POTENTIAL, 1023, 1023);  // both indices out of range
        send_query(OP_POTENTIAL, 2, 3);
        send_query(OP_ACCEL, 0, 0);            // skips the coincident vertex
        send_query(OP_ACCEL, 2, 0);
        send_query(OP_ACCEL, 7, 0);            // target out of range

        configure(4, 0, 0);
        send_query(OP_POTENTIAL, 0, 1);
        send_query(OP_ACCEL, 3, 0);
        configure(3, 15, 48'h0000_0100_0000);
        send_query(OP_POTENTIAL, 0, 2);
        send_query(OP_ACCEL, 1, 0);
        configure(2047, 1, 48'hFFFF_FFFF_FFFF);
        send_query(OP_POTENTIAL, 1023, 5);
        send_query(OP_ACCEL, 1023, 0);         // full table, step of ten

        for (int p = 0; p < 14; p++) begin
            if ($urandom_range(4) == 0) begin
                cnt = $urandom_range(250, 100);
                dim = $urandom_range(2);
                accel_budget = 1;
            end else begin
                cnt = $urandom_range(8, 2);
                dim = $urandom_range(15);
                accel_budget = 4;
            end
            configure(cnt, dim, pick_strength());
            quiet = (p % 5 == 4);
            if (p == 6) long_hold_req = 1;     // receiver holds off, sender keeps going
            repeat (10) random_item();
        end
        quiet = 0;

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
